// ----- src/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_LATER(lbl, clk, rst, ante, n, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_LATER(lbl, clk, rst, ante, n, cons)
`endif
`endif

// ----- src/nbrp_pkg.sv -----
package nbrp_pkg;
   localparam int FRAC_BITS = 16;
   localparam int SUM_W = 19;
   localparam int ALPHA_W = 8;
   localparam int BYTE_W = 8;
   localparam int NUM_W = SUM_W + FRAC_BITS + 1;
   localparam int QW = FRAC_BITS + 1;
   localparam int VW = FRAC_BITS + 2;
   localparam int SQ_W = 2 * FRAC_BITS + 1;
   localparam int SS_W = SQ_W + 1;
   localparam int RT_W = SS_W / 2;
   localparam int SR_W = RT_W + 2;
   localparam int PN_W = RT_W + 10;
   localparam int PR_W = PN_W - BYTE_W;
   localparam int DIV_STEPS = QW;
   localparam int SQRT_STEPS = RT_W;
   localparam int PDIV_STEPS = BYTE_W;
   localparam int ST_V = DIV_STEPS + 1;
   localparam int ST_MUL = ST_V + 1;
   localparam int ST_SUM = ST_MUL + 1;
   localparam int ST_PREP = ST_SUM + SQRT_STEPS + 1;
   localparam int ST_LAST = ST_PREP + PDIV_STEPS;
   localparam int PIPE_LATENCY = ST_LAST + 2;
   localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;
   localparam int CSR_ADDR_W = 3;
   typedef enum logic {
      CSR_FLIP_GREEN = 1'b0,
      CSR_UNUSED = 1'b1
   } csr_idx_type;
endpackage

// ----- src/normal_blend_renormalize_pack.sv -----
// channel   ports                               transfer when
// req       start, busy, req_*                  start high, busy low
// rsp       rsp_valid, rsp_*                    rsp_valid high, one cycle
// csr       psel, penable, pwrite, paddr, ...   psel, penable, pwrite, pready high
//
// one pixel per cycle
// the pipeline holds 17 divide stages, 17 square root stages and 8 pack stages
// busy is always low, results cannot be held off
// reset clears the valid chain and flip_green
`include "assert_macros.svh"
module normal_blend_renormalize_pack (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [nbrp_pkg::SUM_W-1:0] req_sum_red,
   input  logic [nbrp_pkg::SUM_W-1:0] req_sum_green,
   input  logic [nbrp_pkg::SUM_W-1:0] req_sum_blue,
   input  logic [nbrp_pkg::SUM_W-1:0] req_total_weight,
   input  logic [nbrp_pkg::ALPHA_W-1:0] req_alpha,
   output logic rsp_valid,
   output logic [nbrp_pkg::BYTE_W-1:0] rsp_out_red,
   output logic [nbrp_pkg::BYTE_W-1:0] rsp_out_green,
   output logic [nbrp_pkg::BYTE_W-1:0] rsp_out_blue,
   output logic rsp_skipped,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [nbrp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import nbrp_pkg::*;

   logic flip_ff;
   logic valid_ff [0:ST_LAST];
   logic skip_ff [0:ST_LAST];

   logic [SUM_W-1:0] dw_ff [0:DIV_STEPS];
   logic [SUM_W-1:0] drem_ff [0:DIV_STEPS][0:2];
   logic [QW-1:0] dlo_ff [0:DIV_STEPS][0:2];
   logic [QW-1:0] dq_ff [0:DIV_STEPS][0:2];
   logic dsat_ff [0:DIV_STEPS][0:2];
   logic [SUM_W-1:0] drem_in [0:DIV_STEPS][0:2];
   logic [QW-1:0] dlo_in [0:DIV_STEPS][0:2];
   logic [QW-1:0] dq_in [0:DIV_STEPS][0:2];

   logic signed [VW-1:0] v_ff [0:2];
   logic signed [VW-1:0] v_in [0:2];
   logic signed [VW-1:0] mv_ff [0:2];
   logic [SQ_W-1:0] sq_ff [0:2];

   logic [SS_W-1:0] sx_ff [0:SQRT_STEPS];
   logic [SR_W-1:0] srem_ff [0:SQRT_STEPS];
   logic [RT_W-1:0] sroot_ff [0:SQRT_STEPS];
   logic signed [VW-1:0] sv_ff [0:SQRT_STEPS][0:2];
   logic [SS_W-1:0] sx_in [0:SQRT_STEPS];
   logic [SR_W-1:0] srem_in [0:SQRT_STEPS];
   logic [RT_W-1:0] sroot_in [0:SQRT_STEPS];

   logic [RT_W:0] pd_ff [0:PDIV_STEPS];
   logic [PR_W-1:0] prem_ff [0:PDIV_STEPS][0:2];
   logic [BYTE_W-1:0] plo_ff [0:PDIV_STEPS][0:2];
   logic [BYTE_W-1:0] pq_ff [0:PDIV_STEPS][0:2];
   logic [PR_W-1:0] prem_in [0:PDIV_STEPS][0:2];
   logic [BYTE_W-1:0] plo_in [0:PDIV_STEPS][0:2];
   logic [BYTE_W-1:0] pq_in [0:PDIV_STEPS][0:2];

   logic [SUM_W-1:0] w_eff;
   logic [NUM_W-1:0] num0 [0:2];
   logic [SUM_W-1:0] sums [0:2];
   logic [RT_W-1:0] len_c;
   logic [PN_W-1:0] pnum [0:2];

   logic rsp_valid_ff;
   logic rsp_skipped_ff;
   logic [BYTE_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic accept;

   assign accept = start && !busy;
   assign busy = 1'b0;
   assign pready = 1'b1;
   assign prdata = {31'd0, flip_ff};

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready &&
                   csr_idx_type'(paddr[CSR_ADDR_W-1]) == CSR_FLIP_GREEN) begin
         flip_ff <= pwdata[0];
      end
   end

   // input stage
   always_comb begin
      sums[0] = req_sum_red;
      sums[1] = req_sum_green;
      sums[2] = req_sum_blue;
      w_eff = (req_total_weight == '0) ? SUM_W'(1) : req_total_weight;
      for (int c = 0; c < 3; c++) begin
         num0[c] = NUM_W'({sums[c], {FRAC_BITS{1'b0}}}) + NUM_W'(w_eff >> 1);
      end
   end

   // restoring divide, one quotient bit per stage
   always_comb begin
      logic [SUM_W:0] dt;
      for (int k = 0; k <= DIV_STEPS; k++) begin
         for (int c = 0; c < 3; c++) begin
            drem_in[k][c] = drem_ff[k][c];
            dlo_in[k][c] = dlo_ff[k][c];
            dq_in[k][c] = dq_ff[k][c];
         end
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
         for (int c = 0; c < 3; c++) begin
            dt = {drem_ff[k][c], dlo_ff[k][c][QW-1]};
            dlo_in[k+1][c] = dlo_ff[k][c] << 1;
            if (dt >= {1'b0, dw_ff[k]}) begin
               drem_in[k+1][c] = SUM_W'(dt - {1'b0, dw_ff[k]});
               dq_in[k+1][c] = {dq_ff[k][c][QW-2:0], 1'b1};
            end else begin
               drem_in[k+1][c] = dt[SUM_W-1:0];
               dq_in[k+1][c] = {dq_ff[k][c][QW-2:0], 1'b0};
            end
         end
      end
   end

   // average to signed component
   always_comb begin
      logic [QW-1:0] avg;
      for (int c = 0; c < 3; c++) begin
         avg = (dsat_ff[DIV_STEPS][c] || dq_ff[DIV_STEPS][c] > ONE) ?
               ONE : dq_ff[DIV_STEPS][c];
         v_in[c] = $signed({1'b0, avg}) + $signed({1'b0, avg}) - $signed(VW'(ONE));
      end
      if (flip_ff) begin
         v_in[1] = -v_in[1];
      end
   end

   // square root, one root bit per stage
   always_comb begin
      logic [SR_W+1:0] st;
      logic [SR_W-1:0] trial;
      for (int k = 0; k <= SQRT_STEPS; k++) begin
         sx_in[k] = sx_ff[k];
         srem_in[k] = srem_ff[k];
         sroot_in[k] = sroot_ff[k];
      end
      for (int k = 0; k < SQRT_STEPS; k++) begin
         st = {srem_ff[k], sx_ff[k][SS_W-1:SS_W-2]};
         trial = {sroot_ff[k], 2'b01};
         sx_in[k+1] = sx_ff[k] << 2;
         if (st >= {2'b00, trial}) begin
            srem_in[k+1] = SR_W'(st - {2'b00, trial});
            sroot_in[k+1] = {sroot_ff[k][RT_W-2:0], 1'b1};
         end else begin
            srem_in[k+1] = st[SR_W-1:0];
            sroot_in[k+1] = {sroot_ff[k][RT_W-2:0], 1'b0};
         end
      end
   end

   // pack numerator
   always_comb begin
      logic signed [RT_W+1:0] s;
      len_c = (sroot_ff[SQRT_STEPS] == '0) ? RT_W'(1) : sroot_ff[SQRT_STEPS];
      for (int c = 0; c < 3; c++) begin
         s = (RT_W+2)'(sv_ff[SQRT_STEPS][c]) + $signed({2'b00, len_c});
         if (s < 0) begin
            pnum[c] = '0;
         end else begin
            pnum[c] = (PN_W'(unsigned'(s)) << BYTE_W) - PN_W'(unsigned'(s))
                      + PN_W'(len_c);
         end
      end
   end

   // pack divide
   always_comb begin
      logic [PR_W:0] pt;
      for (int k = 0; k <= PDIV_STEPS; k++) begin
         for (int c = 0; c < 3; c++) begin
            prem_in[k][c] = prem_ff[k][c];
            plo_in[k][c] = plo_ff[k][c];
            pq_in[k][c] = pq_ff[k][c];
         end
      end
      for (int k = 0; k < PDIV_STEPS; k++) begin
         for (int c = 0; c < 3; c++) begin
            pt = {prem_ff[k][c], plo_ff[k][c][BYTE_W-1]};
            plo_in[k+1][c] = plo_ff[k][c] << 1;
            if (pt >= (PR_W+1)'(pd_ff[k])) begin
               prem_in[k+1][c] = PR_W'(pt - (PR_W+1)'(pd_ff[k]));
               pq_in[k+1][c] = {pq_ff[k][c][BYTE_W-2:0], 1'b1};
            end else begin
               prem_in[k+1][c] = pt[PR_W-1:0];
               pq_in[k+1][c] = {pq_ff[k][c][BYTE_W-2:0], 1'b0};
            end
         end
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ST_LAST; k++) begin
            valid_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff[0] <= accept;
         for (int k = 1; k <= ST_LAST; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         rsp_valid_ff <= valid_ff[ST_LAST];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      skip_ff[0] <= (req_alpha == '0);
      for (int k = 1; k <= ST_LAST; k++) begin
         skip_ff[k] <= skip_ff[k-1];
      end

      dw_ff[0] <= w_eff;
      for (int c = 0; c < 3; c++) begin
         drem_ff[0][c] <= num0[c][NUM_W-1:QW];
         dlo_ff[0][c] <= num0[c][QW-1:0];
         dq_ff[0][c] <= '0;
         dsat_ff[0][c] <= (num0[c][NUM_W-1:QW] >= w_eff);
      end
      for (int k = 1; k <= DIV_STEPS; k++) begin
         dw_ff[k] <= dw_ff[k-1];
         for (int c = 0; c < 3; c++) begin
            drem_ff[k][c] <= drem_in[k][c];
            dlo_ff[k][c] <= dlo_in[k][c];
            dq_ff[k][c] <= dq_in[k][c];
            dsat_ff[k][c] <= dsat_ff[k-1][c];
         end
      end

      for (int c = 0; c < 3; c++) begin
         v_ff[c] <= v_in[c];
         mv_ff[c] <= v_ff[c];
         sq_ff[c] <= SQ_W'(unsigned'((2*VW)'(v_ff[c]) * (2*VW)'(v_ff[c])));
         sv_ff[0][c] <= mv_ff[c];
      end
      sx_ff[0] <= SS_W'(sq_ff[0]) + SS_W'(sq_ff[1]) + SS_W'(sq_ff[2]);
      srem_ff[0] <= '0;
      sroot_ff[0] <= '0;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
         sx_ff[k] <= sx_in[k];
         srem_ff[k] <= srem_in[k];
         sroot_ff[k] <= sroot_in[k];
         for (int c = 0; c < 3; c++) begin
            sv_ff[k][c] <= sv_ff[k-1][c];
         end
      end

      pd_ff[0] <= {len_c, 1'b0};
      for (int c = 0; c < 3; c++) begin
         prem_ff[0][c] <= pnum[c][PN_W-1:BYTE_W];
         plo_ff[0][c] <= pnum[c][BYTE_W-1:0];
         pq_ff[0][c] <= '0;
      end
      for (int k = 1; k <= PDIV_STEPS; k++) begin
         pd_ff[k] <= pd_ff[k-1];
         for (int c = 0; c < 3; c++) begin
            prem_ff[k][c] <= prem_in[k][c];
            plo_ff[k][c] <= plo_in[k][c];
            pq_ff[k][c] <= pq_in[k][c];
         end
      end

      rsp_skipped_ff <= skip_ff[ST_LAST];
      rsp_red_ff <= skip_ff[ST_LAST] ? '0 : pq_ff[PDIV_STEPS][0];
      rsp_green_ff <= skip_ff[ST_LAST] ? '0 : pq_ff[PDIV_STEPS][1];
      rsp_blue_ff <= skip_ff[ST_LAST] ? '0 : pq_ff[PDIV_STEPS][2];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_skipped = rsp_skipped_ff;
   assign rsp_out_red = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue = rsp_blue_ff;

   `ASSERT_SAME(skip_bytes_zero, clock, reset, rsp_valid && rsp_skipped,
      rsp_out_red == '0 && rsp_out_green == '0 && rsp_out_blue == '0)
   `ASSERT_LATER(result_follows_transfer, clock, reset, start && !busy, 48, rsp_valid)
   `ASSERT_SAME(div_quotient_order, clock, reset,
      valid_ff[DIV_STEPS] && !dsat_ff[DIV_STEPS][0],
      drem_ff[DIV_STEPS][0] < dw_ff[DIV_STEPS])
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
   import nbrp_pkg::*;

   typedef enum logic [1:0] {OP_PIXEL, OP_CSR_WRITE, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type kind;
      logic [SUM_W-1:0] sum_red;
      logic [SUM_W-1:0] sum_green;
      logic [SUM_W-1:0] sum_blue;
      logic [SUM_W-1:0] total_weight;
      logic [ALPHA_W-1:0] alpha;
      logic flip;
      int idle_pct;
   } op_type;

   typedef struct {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic skipped;
   } packed_normal_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [SUM_W-1:0] req_sum_red = '0;
   logic [SUM_W-1:0] req_sum_green = '0;
   logic [SUM_W-1:0] req_sum_blue = '0;
   logic [SUM_W-1:0] req_total_weight = '0;
   logic [ALPHA_W-1:0] req_alpha = '0;
   logic rsp_valid;
   logic [BYTE_W-1:0] rsp_out_red;
   logic [BYTE_W-1:0] rsp_out_green;
   logic [BYTE_W-1:0] rsp_out_blue;
   logic rsp_skipped;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   op_type pending_ops[$];
   packed_normal_type expected_normals[$];
   logic flip_green_copy = 1'b0;
   logic pending_flip = 1'b0;
   int bus_phase = 0;
   int quiet_cycles = 0;
   bit failed = 1'b0;

   normal_blend_renormalize_pack uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 24; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] to_byte(longint v, longint len);
      longint num;
      longint q;
      num = 255 * (v + len) + len;
      if (num < 0) return '0;
      q = num / (2 * len);
      if (q > 255) q = 255;
      return BYTE_W'(q);
   endfunction

   function automatic packed_normal_type renormalize(op_type p, logic flip);
      packed_normal_type r;
      longint w;
      longint avg;
      longint v[3];
      longint unsigned sq;
      longint len;
      logic [SUM_W-1:0] sums[3];
      sums[0] = p.sum_red;
      sums[1] = p.sum_green;
      sums[2] = p.sum_blue;
      if (p.alpha == 0) begin
         r.red = '0;
         r.green = '0;
         r.blue = '0;
         r.skipped = 1'b1;
         return r;
      end
      w = (p.total_weight == 0) ? 1 : longint'(p.total_weight);
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         avg = ((longint'(sums[i]) << FRAC_BITS) + (w >> 1)) / w;
         if (avg > (64'd1 << FRAC_BITS)) avg = 64'd1 << FRAC_BITS;
         v[i] = 2 * avg - (64'd1 << FRAC_BITS);
      end
      if (flip) v[1] = -v[1];
      for (int i = 0; i < 3; i++) sq += longint'(v[i] * v[i]);
      len = longint'(int_sqrt(sq));
      if (len < 1) len = 1;
      r.red = to_byte(v[0], len);
      r.green = to_byte(v[1], len);
      r.blue = to_byte(v[2], len);
      r.skipped = 1'b0;
      return r;
   endfunction

   function automatic op_type pixel(int sr, int sg, int sb, int tw, int a, int pct);
      op_type p;
      p.kind = OP_PIXEL;
      p.sum_red = SUM_W'(sr);
      p.sum_green = SUM_W'(sg);
      p.sum_blue = SUM_W'(sb);
      p.total_weight = SUM_W'(tw);
      p.alpha = ALPHA_W'(a);
      p.flip = 1'b0;
      p.idle_pct = pct;
      return p;
   endfunction

   function automatic op_type control(op_kind_type k, logic f);
      op_type p;
      p = pixel(0, 0, 0, 0, 0, 0);
      p.kind = k;
      p.flip = f;
      return p;
   endfunction

   function automatic op_type random_pixel(int pct);
      int tw;
      int sel;
      sel = int'($urandom_range(99));
      if (sel < 70) begin
         tw = (sel < 15) ? int'($urandom_range(4)) : int'($urandom_range(524287));
         return pixel(int'($urandom_range(tw)), int'($urandom_range(tw)),
                      int'($urandom_range(tw)), tw,
                      ($urandom_range(9) == 0) ? 0 : int'($urandom_range(255)), pct);
      end
      return pixel(int'($urandom_range(524287)), int'($urandom_range(524287)),
                   int'($urandom_range(524287)), int'($urandom_range(524287)),
                   int'($urandom_range(255)), pct);
   endfunction

   task automatic queue_op(op_type p);
      pending_ops.insert(pending_ops.size(), p);
   endtask

   task automatic add_directed(int pct);
      queue_op(pixel(1000, 2000, 3000, 4000, 0, pct));
      queue_op(pixel(524287, 524287, 524287, 524287, 0, pct));
      queue_op(pixel(100, 200, 300, 0, 10, pct));
      queue_op(pixel(0, 0, 0, 0, 1, pct));
      queue_op(pixel(524287, 524287, 524287, 524287, 255, pct));
      queue_op(pixel(524287, 0, 0, 65536, 255, pct));
      queue_op(pixel(32768, 32768, 32768, 65536, 128, pct));
      queue_op(pixel(0, 0, 65536, 65536, 200, pct));
      queue_op(pixel(0, 65536, 0, 65536, 200, pct));
      queue_op(pixel(65536, 0, 32768, 65536, 1, pct));
      queue_op(pixel(1, 2, 3, 4, 77, pct));
      queue_op(pixel(0, 524287, 1, 1, 255, pct));
   endtask

   initial begin
      queue_op(control(OP_CSR_WRITE, 1'b0));
      add_directed(0);
      queue_op(control(OP_DRAIN, 1'b0));
      queue_op(control(OP_CSR_WRITE, 1'b1));
      add_directed(0);
      for (int i = 0; i < 300; i++) queue_op(random_pixel(15));
      queue_op(control(OP_DRAIN, 1'b0));
      queue_op(control(OP_CSR_WRITE, 1'b0));
      for (int i = 0; i < 300; i++) queue_op(random_pixel(71));
      queue_op(control(OP_DRAIN, 1'b0));
      queue_op(control(OP_CSR_WRITE, 1'b1));
      for (int i = 0; i < 300; i++) queue_op(random_pixel(0));
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_ops.size() == 0 && bus_phase == 0 && !start
            && expected_normals.size() == 0);
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (!failed) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      logic took;
      op_type cur;
      op_type nxt;
      took = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            cur.kind = OP_PIXEL;
            cur.sum_red = req_sum_red;
            cur.sum_green = req_sum_green;
            cur.sum_blue = req_sum_blue;
            cur.total_weight = req_total_weight;
            cur.alpha = req_alpha;
            cur.flip = 1'b0;
            cur.idle_pct = 0;
            expected_normals.insert(expected_normals.size(),
                                    renormalize(cur, flip_green_copy));
            took = 1'b1;
         end
         if (bus_phase == 1) begin
            penable <= 1'b1;
            bus_phase <= 2;
         end else if (bus_phase == 2) begin
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            flip_green_copy <= pending_flip;
            bus_phase <= 0;
         end else if (start && !took) begin
            // held item not yet taken
         end else if (pending_ops.size() == 0) begin
            start <= 1'b0;
         end else begin
            nxt = pending_ops[0];
            if (nxt.kind == OP_PIXEL) begin
               if (int'($urandom_range(99)) < nxt.idle_pct) begin
                  start <= 1'b0;
               end else begin
                  void'(pending_ops.pop_front());
                  start <= 1'b1;
                  req_sum_red <= nxt.sum_red;
                  req_sum_green <= nxt.sum_green;
                  req_sum_blue <= nxt.sum_blue;
                  req_total_weight <= nxt.total_weight;
                  req_alpha <= nxt.alpha;
               end
            end else begin
               start <= 1'b0;
               if (!took && !start && expected_normals.size() == 0) begin
                  void'(pending_ops.pop_front());
                  if (nxt.kind == OP_CSR_WRITE) begin
                     psel <= 1'b1;
                     pwrite <= 1'b1;
                     paddr <= CSR_ADDR_W'(4 * CSR_FLIP_GREEN);
                     pwdata <= {31'd0, nxt.flip};
                     pending_flip <= nxt.flip;
                     bus_phase <= 1;
                  end
               end
            end
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      packed_normal_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid || (start && !busy) || bus_phase != 0) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 5000) begin
            $display("== FAIL ==");
            $finish;
         end
         if (rsp_valid) begin
            if (expected_normals.size() == 0) begin
               $display("%0t unexpected transfer: red %0d green %0d blue %0d skipped %0d",
                        $time, rsp_out_red, rsp_out_green, rsp_out_blue, rsp_skipped);
               failed = 1'b1;
            end else begin
               want = expected_normals.pop_front();
               if (rsp_out_red !== want.red) begin
                  $display("%0t out_red expected %0d actual %0d", $time, want.red, rsp_out_red);
                  failed = 1'b1;
               end
               if (rsp_out_green !== want.green) begin
                  $display("%0t out_green expected %0d actual %0d", $time, want.green,
                           rsp_out_green);
                  failed = 1'b1;
               end
               if (rsp_out_blue !== want.blue) begin
                  $display("%0t out_blue expected %0d actual %0d", $time, want.blue,
                           rsp_out_blue);
                  failed = 1'b1;
               end
               if (rsp_skipped !== want.skipped) begin
                  $display("%0t skipped expected %0d actual %0d", $time, want.skipped,
                           rsp_skipped);
                  failed = 1'b1;
               end
            end
         end
      end
   end
endmodule
